// ===== rtl/core/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// lkvc_pkg
// Types and constants for the LRU key-value cache unit: request and
// response payloads, operation codes and the capacity register layout.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int CSR_W = 5;

   localparam logic [CSR_W-1:0] CAP_RESET  = 5'd16;
   localparam logic             FUNC_GET   = 1'b0;
   localparam logic             FUNC_PUT   = 1'b1;
   localparam logic [31:0]      MISS_VALUE = 32'hFFFF_FFFF;

   typedef struct packed {
      logic               func;
      logic signed [31:0] key;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] read_value;
      logic               evicted;
   } rsp_type;

endpackage

// ===== rtl/core/lru_key_value_cache_unit.sv =====
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with LRU replacement, scanned one entry
// per cycle through a single shared key/rank compare unit.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake            | payload
//   ---------+-----+----------------------+------------------------
//   req      | in  | req_valid / req_stall| req_data  (req_type)
//   rsp      | out | rsp_valid / rsp_stall| rsp_data  (rsp_type)
//   csr      | in  | csr_valid / csr_ready| csr_data  (capacity_in_use)
//
// A get miss does one lookup sweep over all entries; any other request
// does that lookup sweep and then one rank update sweep, each
// reading one entry per cycle from the key and rank memories.
// Reset clears valid bits, entry count, state and the response valid flag;
// the capacity register resets to 16.
// req_stall is high from acceptance until the response is loaded; a
// stalled response register holds the sequencer in its final state.
//
module lru_key_value_cache_unit
   import lkvc_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RankW = IdxW;
   localparam int CntW  = $clog2(CAPACITY + 1);
   localparam int CmpW  = (CntW > CSR_W) ? CntW : CSR_W;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN     = 3'd1;
   localparam logic [2:0] ST_SCAN_END = 3'd2;
   localparam logic [2:0] ST_DECIDE   = 3'd3;
   localparam logic [2:0] ST_UPD      = 3'd4;
   localparam logic [2:0] ST_UPD_END  = 3'd5;
   localparam logic [2:0] ST_FINISH   = 3'd6;

   // entry storage
   logic [31:0]      key_mem  [CAPACITY];
   logic [31:0]      val_mem  [CAPACITY];
   logic [RankW-1:0] rank_mem [CAPACITY];

   logic [2:0]          state_ff, state_in;
   logic [IdxW-1:0]     cnt_ff, cnt_in;
   logic                pipe_vld_ff, pipe_vld_in;
   logic [IdxW-1:0]     pipe_idx_ff, pipe_idx_in;
   req_type             req_ff, req_in;
   logic [31:0]         key_rd_ff;
   logic [31:0]         val_rd_ff;
   logic [RankW-1:0]    rank_rd_ff;
   logic                hit_ff, hit_in;
   logic [IdxW-1:0]     hit_slot_ff, hit_slot_in;
   logic [RankW-1:0]    hit_rank_ff, hit_rank_in;
   logic                free_found_ff, free_found_in;
   logic [IdxW-1:0]     free_slot_ff, free_slot_in;
   logic                vic_found_ff, vic_found_in;
   logic [IdxW-1:0]     vic_slot_ff, vic_slot_in;
   logic [RankW-1:0]    vic_rank_ff, vic_rank_in;
   logic                evict_ff, evict_in;
   logic [IdxW-1:0]     upd_slot_ff, upd_slot_in;
   logic                age_ff, age_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic [CSR_W-1:0]    cap_ff, cap_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic             key_we, val_we, rank_we;
   logic [IdxW-1:0]  key_waddr, val_waddr, rank_waddr;
   logic [31:0]      val_wdata;
   logic [RankW-1:0] rank_wdata;

   logic            pipe_valid_bit;
   logic            key_match;
   logic [CmpW-1:0] cap_ext, cap_eff;
   logic            evict_now;
   logic            ins_ok;
   logic [IdxW-1:0] ins_slot;
   logic            rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign pipe_valid_bit = valid_ff[pipe_idx_ff];
   assign key_match      = pipe_valid_bit && (key_rd_ff == req_ff.key);
   assign rsp_free       = !rsp_valid_ff || !rsp_stall;

   // capacity register: zero reads as one, saturates at CAPACITY
   assign cap_ext = CmpW'(cap_ff);
   assign cap_eff = (cap_ff == '0) ? CmpW'(1) :
                    ((cap_ext > CmpW'(CAPACITY)) ? CmpW'(CAPACITY) : cap_ext);
   assign evict_now = (req_ff.func == FUNC_PUT) && !hit_ff &&
                      (CmpW'(count_ff) >= cap_eff);

   // evicted slot frees up before the lowest free slot is chosen
   always_comb begin
      if (evict_now) begin
         ins_ok   = vic_found_ff;
         ins_slot = (free_found_ff && (free_slot_ff < vic_slot_ff)) ?
                    free_slot_ff : vic_slot_ff;
      end else begin
         ins_ok   = free_found_ff;
         ins_slot = free_slot_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = cnt_ff;
      req_in        = req_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      vic_found_in  = vic_found_ff;
      vic_slot_in   = vic_slot_ff;
      vic_rank_in   = vic_rank_ff;
      evict_in      = evict_ff;
      upd_slot_in   = upd_slot_ff;
      age_in        = age_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      key_we        = 1'b0;
      key_waddr     = ins_slot;
      val_we        = 1'b0;
      val_waddr     = ins_slot;
      val_wdata     = req_ff.value;
      rank_we       = 1'b0;
      rank_waddr    = pipe_idx_ff;
      rank_wdata    = '0;

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // lookup sweep: first match, lowest free slot, oldest valid entry
      if (pipe_vld_ff && (state_ff == ST_SCAN || state_ff == ST_SCAN_END)) begin
         if (key_match && !hit_ff) begin
            hit_in      = 1'b1;
            hit_slot_in = pipe_idx_ff;
            hit_rank_in = rank_rd_ff;
         end
         if (!pipe_valid_bit && !free_found_ff) begin
            free_found_in = 1'b1;
            free_slot_in  = pipe_idx_ff;
         end
         if (pipe_valid_bit && (!vic_found_ff || rank_rd_ff > vic_rank_ff)) begin
            vic_found_in = 1'b1;
            vic_slot_in  = pipe_idx_ff;
            vic_rank_in  = rank_rd_ff;
         end
      end

      // rank sweep: target goes to zero, younger (or all) valid entries age
      if (pipe_vld_ff && (state_ff == ST_UPD || state_ff == ST_UPD_END)) begin
         if (pipe_idx_ff == upd_slot_ff) begin
            rank_we    = 1'b1;
            rank_wdata = '0;
         end else if (pipe_valid_bit && (age_ff || rank_rd_ff < hit_rank_ff)) begin
            rank_we    = 1'b1;
            rank_wdata = rank_rd_ff + RankW'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               cnt_in        = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               vic_found_in  = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pipe_vld_in = 1'b1;
            if (cnt_ff == LastIdx) begin
               state_in = ST_SCAN_END;
            end else begin
               cnt_in = cnt_ff + IdxW'(1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cnt_in   = '0;
            evict_in = evict_now;
            if (hit_ff) begin
               upd_slot_in = hit_slot_ff;
               age_in      = 1'b0;
               state_in    = ST_UPD;
               if (req_ff.func == FUNC_PUT) begin
                  val_we    = 1'b1;
                  val_waddr = hit_slot_ff;
               end
            end else if (req_ff.func == FUNC_PUT) begin
               if (evict_now && vic_found_ff) begin
                  valid_in[vic_slot_ff] = 1'b0;
                  count_in              = count_in - CntW'(1);
               end
               if (ins_ok) begin
                  valid_in[ins_slot] = 1'b1;
                  count_in           = count_in + CntW'(1);
                  key_we             = 1'b1;
                  val_we             = 1'b1;
                  upd_slot_in        = ins_slot;
                  age_in             = 1'b1;
                  state_in           = ST_UPD;
               end else begin
                  state_in = ST_FINISH;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_UPD: begin
            pipe_vld_in = 1'b1;
            if (cnt_ff == LastIdx) begin
               state_in = ST_UPD_END;
            end else begin
               cnt_in = cnt_ff + IdxW'(1);
            end
         end
         ST_UPD_END: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.hit     = hit_ff;
               rsp_data_in.evicted = evict_ff && (req_ff.func == FUNC_PUT) && !hit_ff;
               rsp_data_in.read_value = (req_ff.func == FUNC_GET && hit_ff) ?
                                        val_rd_ff : MISS_VALUE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pipe_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pipe_vld_ff  <= pipe_vld_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      pipe_idx_ff   <= pipe_idx_in;
      req_ff        <= req_in;
      hit_ff        <= hit_in;
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      vic_found_ff  <= vic_found_in;
      vic_slot_ff   <= vic_slot_in;
      vic_rank_ff   <= vic_rank_in;
      evict_ff      <= evict_in;
      upd_slot_ff   <= upd_slot_in;
      age_ff        <= age_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= req_ff.key;
      end
      key_rd_ff <= key_mem[cnt_ff];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      val_rd_ff <= val_mem[hit_slot_ff];
   end

   always_ff @(posedge clock) begin
      if (rank_we) begin
         rank_mem[rank_waddr] <= rank_wdata;
      end
      rank_rd_ff <= rank_mem[cnt_ff];
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(count_ff))
      else $error("entry count out of step with valid bits");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response loaded outside final state");

   a_stall_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD) |-> req_stall && !$past(state_ff == ST_IDLE))
      else $error("rank sweep entered without a lookup");
`endif

endmodule
